### hw/rtl/accumulator_cpu_step_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro needs signals named clk and rst in the scope where it is used.
`ifndef ACCUMULATOR_CPU_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/acs_pkg.sv
`timescale 1ns / 1ps
package acs_pkg;

  localparam int WORD_BITS      = 8;
  localparam int MEM_DEPTH      = 256;
  localparam int ADDR_BITS      = $clog2(MEM_DEPTH);
  localparam int BREAK_SLOTS    = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_EN  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_OP0 = 3'd1;

  // Opcodes.
  localparam word_t OP_LOAD_IMM  = 8'd0;
  localparam word_t OP_LOAD_DIR  = 8'd64;
  localparam word_t OP_LOAD_IND  = 8'd192;
  localparam word_t OP_ADD_IMM   = 8'd32;
  localparam word_t OP_ADD_DIR   = 8'd96;
  localparam word_t OP_ADD_IND   = 8'd224;
  localparam word_t OP_SUB_IMM   = 8'd33;
  localparam word_t OP_SUB_DIR   = 8'd97;
  localparam word_t OP_SUB_IND   = 8'd225;
  localparam word_t OP_NAND_IMM  = 8'd34;
  localparam word_t OP_NAND_DIR  = 8'd98;
  localparam word_t OP_NAND_IND  = 8'd226;
  localparam word_t OP_STORE_DIR = 8'd72;
  localparam word_t OP_STORE_IND = 8'd200;
  localparam word_t OP_IN_DIR    = 8'd73;
  localparam word_t OP_IN_IND    = 8'd201;
  localparam word_t OP_OUT_DIR   = 8'd65;
  localparam word_t OP_OUT_IND   = 8'd193;
  localparam word_t OP_JUMP      = 8'd16;
  localparam word_t OP_BRN       = 8'd17;
  localparam word_t OP_BRZ       = 8'd18;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_START = 2'd2,
    ACT_EXEC  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BREAK   = 2'd1,
    ST_INVALID = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_NAND = 2'd2,
    ALU_PASS = 2'd3
  } alu_op_t;

  typedef enum logic [2:0] {
    K_LOAD      = 3'd0,
    K_ALU       = 3'd1,
    K_STORE_ACC = 3'd2,
    K_STORE_IN  = 3'd3,
    K_OUT       = 3'd4,
    K_JUMP      = 3'd5,
    K_BRN       = 3'd6,
    K_BRZ       = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    M_IMM = 2'd0,
    M_DIR = 2'd1,
    M_IND = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_ISSUE   = 3'd1,
    S_MEMRD   = 3'd2,
    S_OPCODE  = 3'd3,
    S_OPERAND = 3'd4,
    S_PTR     = 3'd5,
    S_VALUE   = 3'd6,
    S_EXEC    = 3'd7
  } state_t;

  typedef struct packed {
    logic    ok;
    kind_t   kind;
    mode_t   mode;
    alu_op_t alu;
  } dec_t;

  function automatic dec_t decode(input word_t op);
    dec_t d;
    d      = '0;
    d.ok   = 1'b1;
    d.kind = K_ALU;
    d.mode = M_IMM;
    d.alu  = ALU_PASS;
    case (op)
      OP_LOAD_IMM:  begin d.kind = K_LOAD; end
      OP_LOAD_DIR:  begin d.kind = K_LOAD; d.mode = M_DIR; end
      OP_LOAD_IND:  begin d.kind = K_LOAD; d.mode = M_IND; end
      OP_ADD_IMM:   begin d.alu = ALU_ADD; end
      OP_ADD_DIR:   begin d.alu = ALU_ADD; d.mode = M_DIR; end
      OP_ADD_IND:   begin d.alu = ALU_ADD; d.mode = M_IND; end
      OP_SUB_IMM:   begin d.alu = ALU_SUB; end
      OP_SUB_DIR:   begin d.alu = ALU_SUB; d.mode = M_DIR; end
      OP_SUB_IND:   begin d.alu = ALU_SUB; d.mode = M_IND; end
      OP_NAND_IMM:  begin d.alu = ALU_NAND; end
      OP_NAND_DIR:  begin d.alu = ALU_NAND; d.mode = M_DIR; end
      OP_NAND_IND:  begin d.alu = ALU_NAND; d.mode = M_IND; end
      OP_STORE_DIR: begin d.kind = K_STORE_ACC; d.mode = M_DIR; end
      OP_STORE_IND: begin d.kind = K_STORE_ACC; d.mode = M_IND; end
      OP_IN_DIR:    begin d.kind = K_STORE_IN; d.mode = M_DIR; end
      OP_IN_IND:    begin d.kind = K_STORE_IN; d.mode = M_IND; end
      OP_OUT_DIR:   begin d.kind = K_OUT; d.mode = M_DIR; end
      OP_OUT_IND:   begin d.kind = K_OUT; d.mode = M_IND; end
      OP_JUMP:      begin d.kind = K_JUMP; end
      OP_BRN:       begin d.kind = K_BRN; end
      OP_BRZ:       begin d.kind = K_BRZ; end
      default:      begin d.ok = 1'b0; end
    endcase
    return d;
  endfunction

  // A word is used as an address by its unsigned bit pattern.
  function automatic addr_t to_addr(input word_t w);
    return ADDR_BITS'(w);
  endfunction

endpackage

### hw/rtl/acs_ram.sv
`timescale 1ns / 1ps
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/acs_alu.sv
`timescale 1ns / 1ps
module acs_alu (
  input  acs_pkg::alu_op_t op,
  input  acs_pkg::word_t   a,
  input  acs_pkg::word_t   b,
  output acs_pkg::word_t   y
);

  always_comb begin
    case (op)
      acs_pkg::ALU_ADD:  y = a + b;
      acs_pkg::ALU_SUB:  y = a - b;
      acs_pkg::ALU_NAND: y = ~(a & b);
      acs_pkg::ALU_PASS: y = b;
      default:           y = b;
    endcase
  end

endmodule

### hw/rtl/accumulator_cpu_step.sv
`timescale 1ns / 1ps
// Channel        | Ports                                          | Transfer when
// ---------------+------------------------------------------------+------------------
// item in        | start, busy, action, address, data,            | start && !busy
//                | check_breaks                                   |
// result out     | done, status, out_valid, out_value, read_data, | done (one cycle)
//                | pc_now, acc_now, last_opcode                   |
// configuration  | cfg_we, cfg_index, cfg_data                    | cfg_we
//
// An item enters the issue state, where a write, start or refused execute ends; a read
// adds the memory-read state. An execute fetches the opcode, where a breakpoint or
// invalid-opcode stop ends, then the operand; direct load/ALU/OUT and all indirect
// forms add the pointer state, indirect load/ALU/OUT the value state, and all end in
// the execute state. Each dependent access goes through the registered read of the
// single memory port. Busy is already low in the done cycle, so the next item may
// transfer there. Synchronous reset clears the program counter, the accumulator, the
// halt flag and the breakpoint registers, not memory. The receiver cannot stall.
module accumulator_cpu_step (
  input  logic                                  clk,
  input  logic                                  rst,
  // Item port
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            action,
  input  logic [7:0]                            address,
  input  logic signed [7:0]                     data,
  input  logic                                  check_breaks,
  // Configuration port
  input  logic                                  cfg_we,
  input  logic [acs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [acs_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // Result port
  output logic                                  done,
  output logic [1:0]                            status,
  output logic                                  out_valid,
  output logic signed [7:0]                     out_value,
  output logic signed [7:0]                     read_data,
  output logic [7:0]                            pc_now,
  output logic signed [7:0]                     acc_now,
  output logic [7:0]                            last_opcode
);

  acs_pkg::state_t state, state_next;

  // Latched item.
  acs_pkg::action_t act;
  acs_pkg::addr_t   addr_r;
  acs_pkg::word_t   data_r;
  logic             chk_r;

  // Machine state.
  acs_pkg::addr_t pc;
  acs_pkg::word_t acc;
  logic           halted;

  // Breakpoint registers.
  logic [acs_pkg::BREAK_SLOTS-1:0] brk_en;
  acs_pkg::word_t                  brk_op [acs_pkg::BREAK_SLOTS];

  // Per-instruction working registers.
  acs_pkg::word_t opcode;
  acs_pkg::dec_t  dec_r;
  acs_pkg::word_t imm;
  acs_pkg::word_t val;

  // Result registers.
  acs_pkg::status_t res_status, res_status_next;
  logic             res_out_valid, res_out_valid_next;
  acs_pkg::word_t   res_out_value, res_out_value_next;
  acs_pkg::word_t   res_read_data, res_read_data_next;
  acs_pkg::word_t   res_last_op, res_last_op_next;

  // Memory port and ALU wiring.
  logic           ram_we;
  acs_pkg::addr_t ram_addr;
  acs_pkg::word_t ram_wdata;
  acs_pkg::word_t ram_rdata;
  acs_pkg::word_t alu_b;
  acs_pkg::word_t alu_y;

  acs_pkg::dec_t dec_now;
  logic          brk_hit;
  logic          finish;
  logic          is_store;
  logic          take_branch;

  acs_ram #(
    .WIDTH (acs_pkg::WORD_BITS),
    .DEPTH (acs_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  acs_alu u_alu (
    .op (dec_r.alu),
    .a  (acc),
    .b  (alu_b),
    .y  (alu_y)
  );

  // The opcode is decoded as it comes out of the memory read register.
  assign dec_now = acs_pkg::decode(ram_rdata);

  always_comb begin
    brk_hit = 1'b0;
    for (int i = 0; i < acs_pkg::BREAK_SLOTS; i++) begin
      if (brk_en[i] && (brk_op[i] == ram_rdata)) begin
        brk_hit = 1'b1;
      end
    end
  end

  assign is_store = (dec_r.kind == acs_pkg::K_STORE_ACC) ||
                    (dec_r.kind == acs_pkg::K_STORE_IN);

  // Immediate forms take the operand word itself; all others the fetched value.
  assign alu_b = (dec_r.mode == acs_pkg::M_IMM) ? imm : val;

  always_comb begin
    case (dec_r.kind)
      acs_pkg::K_JUMP: take_branch = 1'b1;
      acs_pkg::K_BRN:  take_branch = acc[acs_pkg::WORD_BITS-1];
      acs_pkg::K_BRZ:  take_branch = (acc == '0);
      default:         take_branch = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      acs_pkg::S_IDLE: begin
        if (start) begin
          state_next = acs_pkg::S_ISSUE;
        end
      end
      acs_pkg::S_ISSUE: begin
        case (act)
          acs_pkg::ACT_READ: state_next = acs_pkg::S_MEMRD;
          acs_pkg::ACT_EXEC: state_next = halted ? acs_pkg::S_IDLE : acs_pkg::S_OPCODE;
          default:           state_next = acs_pkg::S_IDLE;
        endcase
      end
      acs_pkg::S_MEMRD: state_next = acs_pkg::S_IDLE;
      acs_pkg::S_OPCODE: begin
        if ((chk_r && brk_hit) || !dec_now.ok) begin
          state_next = acs_pkg::S_IDLE;
        end else begin
          state_next = acs_pkg::S_OPERAND;
        end
      end
      acs_pkg::S_OPERAND: begin
        // Direct stores only need the operand as their address.
        if ((dec_r.mode == acs_pkg::M_IMM) || ((dec_r.mode == acs_pkg::M_DIR) && is_store)) begin
          state_next = acs_pkg::S_EXEC;
        end else begin
          state_next = acs_pkg::S_PTR;
        end
      end
      acs_pkg::S_PTR: begin
        // Indirect stores stop at the pointer, which is their address.
        if ((dec_r.mode == acs_pkg::M_DIR) || is_store) begin
          state_next = acs_pkg::S_EXEC;
        end else begin
          state_next = acs_pkg::S_VALUE;
        end
      end
      acs_pkg::S_VALUE: state_next = acs_pkg::S_EXEC;
      acs_pkg::S_EXEC:  state_next = acs_pkg::S_IDLE;
      default:          state_next = acs_pkg::S_IDLE;
    endcase
  end

  assign finish = (state != acs_pkg::S_IDLE) && (state_next == acs_pkg::S_IDLE);

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc;
    ram_wdata = data_r;
    case (state)
      acs_pkg::S_ISSUE: begin
        case (act)
          acs_pkg::ACT_WRITE: begin
            ram_we   = 1'b1;
            ram_addr = addr_r;
          end
          acs_pkg::ACT_READ: ram_addr = addr_r;
          default:           ram_addr = pc;
        endcase
      end
      acs_pkg::S_OPCODE:  ram_addr = pc + acs_pkg::ADDR_BITS'(1);
      acs_pkg::S_OPERAND: ram_addr = acs_pkg::to_addr(ram_rdata);
      acs_pkg::S_PTR:     ram_addr = acs_pkg::to_addr(ram_rdata);
      acs_pkg::S_EXEC: begin
        ram_we    = is_store;
        ram_addr  = (dec_r.mode == acs_pkg::M_DIR) ? acs_pkg::to_addr(imm)
                                                   : acs_pkg::to_addr(val);
        ram_wdata = (dec_r.kind == acs_pkg::K_STORE_ACC) ? acc : data_r;
      end
      default: ram_addr = pc;
    endcase
  end

  // Result values, taken into the result registers when the item finishes.
  always_comb begin
    res_status_next    = acs_pkg::ST_DONE;
    res_out_valid_next = 1'b0;
    res_out_value_next = '0;
    res_read_data_next = '0;
    res_last_op_next   = '0;
    case (state)
      acs_pkg::S_ISSUE: begin
        if ((act == acs_pkg::ACT_EXEC) && halted) begin
          res_status_next = acs_pkg::ST_REFUSED;
        end
      end
      acs_pkg::S_MEMRD: res_read_data_next = ram_rdata;
      acs_pkg::S_OPCODE: begin
        res_last_op_next = ram_rdata;
        if (chk_r && brk_hit) begin
          res_status_next = acs_pkg::ST_BREAK;
        end else if (!dec_now.ok) begin
          res_status_next = acs_pkg::ST_INVALID;
        end
      end
      acs_pkg::S_EXEC: begin
        res_last_op_next = opcode;
        if (dec_r.kind == acs_pkg::K_OUT) begin
          res_out_valid_next = 1'b1;
          res_out_value_next = val;
        end
      end
      default: res_status_next = acs_pkg::ST_DONE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= acs_pkg::S_IDLE;
      done   <= 1'b0;
      pc     <= '0;
      acc    <= '0;
      halted <= 1'b0;
      brk_en <= '0;
      for (int i = 0; i < acs_pkg::BREAK_SLOTS; i++) begin
        brk_op[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= finish;

      if (cfg_we) begin
        if (cfg_index == acs_pkg::REG_BREAK_EN) begin
          brk_en <= cfg_data[acs_pkg::BREAK_SLOTS-1:0];
        end
        for (int i = 0; i < acs_pkg::BREAK_SLOTS; i++) begin
          if (cfg_index == acs_pkg::CFG_INDEX_BITS'(acs_pkg::REG_BREAK_OP0 + i)) begin
            brk_op[i] <= acs_pkg::WORD_BITS'(cfg_data);
          end
        end
      end

      case (state)
        acs_pkg::S_ISSUE: begin
          if (act == acs_pkg::ACT_START) begin
            pc     <= addr_r;
            acc    <= '0;
            halted <= 1'b0;
          end
        end
        acs_pkg::S_OPCODE: begin
          if (!(chk_r && brk_hit) && !dec_now.ok) begin
            halted <= 1'b1;
          end
        end
        acs_pkg::S_EXEC: begin
          if ((dec_r.kind == acs_pkg::K_LOAD) || (dec_r.kind == acs_pkg::K_ALU)) begin
            acc <= alu_y;
          end
          pc <= take_branch ? acs_pkg::to_addr(imm) : pc + acs_pkg::ADDR_BITS'(2);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state == acs_pkg::S_IDLE) && start) begin
      act    <= acs_pkg::action_t'(action);
      addr_r <= acs_pkg::ADDR_BITS'(address);
      data_r <= acs_pkg::WORD_BITS'(data);
      chk_r  <= check_breaks;
    end
    if (state == acs_pkg::S_OPCODE) begin
      opcode <= ram_rdata;
      dec_r  <= dec_now;
    end
    if (state == acs_pkg::S_OPERAND) begin
      imm <= ram_rdata;
    end
    if ((state == acs_pkg::S_PTR) || (state == acs_pkg::S_VALUE)) begin
      val <= ram_rdata;
    end
    if (finish) begin
      res_status    <= res_status_next;
      res_out_valid <= res_out_valid_next;
      res_out_value <= res_out_value_next;
      res_read_data <= res_read_data_next;
      res_last_op   <= res_last_op_next;
    end
  end

  assign busy        = (state != acs_pkg::S_IDLE);
  assign status      = res_status;
  assign out_valid   = res_out_valid;
  assign out_value   = res_out_value;
  assign read_data   = res_read_data;
  assign pc_now      = 8'(pc);
  assign acc_now     = acc;
  assign last_opcode = res_last_op;

endmodule

### hw/rtl/acs_check.sv
`timescale 1ns / 1ps
`include "accumulator_cpu_step_macros.svh"
module acs_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic       out_valid,
  input logic [7:0] read_data
);

  // An accepted item always keeps the block busy in the next cycle.
  `ACS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")

  // The done strobe lasts exactly one cycle.
  `ACS_ASSERT_NEXT(a_done_pulse, done, !done, "done held for more than one cycle")

  // With nothing in flight and no transfer, no result may appear.
  `ACS_ASSERT_NEXT(a_no_spurious, !busy && !start, !done, "result without an item")

  // A stopped or refused execute neither outputs nor reads a word.
  `ACS_ASSERT_SAME(a_stop_quiet,
    done && (status == acs_pkg::ST_BREAK || status == acs_pkg::ST_INVALID ||
             status == acs_pkg::ST_REFUSED),
    !out_valid && (read_data == 8'd0), "stopped execute reported data")

endmodule

bind accumulator_cpu_step acs_check u_acs_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .out_valid (out_valid),
  .read_data (read_data)
);

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import acs_pkg::*;

  // Cycles with neither an input transfer nor a result before the run is declared hung.
  // A sender that idles 88 percent of the time rarely leaves a gap near this limit.
  localparam int QUIET_LIMIT = 4000;
  // Cycles allowed after the last result before the block is taken as idle.
  // The slowest command is an indirect load, ALU or OUT.
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CMDS = 230;
  localparam int MAX_REPORTS = 10;

  // One command as the block sees it, and the result it must return.
  typedef struct packed {
    action_t action;
    addr_t   address;
    word_t   data;
    logic    check_breaks;
  } cmd_t;

  typedef struct packed {
    status_t status;
    logic    out_valid;
    word_t   out_value;
    word_t   read_data;
    addr_t   pc;
    word_t   acc;
    word_t   opcode;
  } step_result_t;

  localparam word_t LEGAL_OPS [21] = '{
    OP_LOAD_IMM, OP_LOAD_DIR, OP_LOAD_IND, OP_ADD_IMM, OP_ADD_DIR, OP_ADD_IND,
    OP_SUB_IMM, OP_SUB_DIR, OP_SUB_IND, OP_NAND_IMM, OP_NAND_DIR, OP_NAND_IND,
    OP_STORE_DIR, OP_STORE_IND, OP_IN_DIR, OP_IN_IND, OP_OUT_DIR, OP_OUT_IND,
    OP_JUMP, OP_BRN, OP_BRZ
  };

  // A short program at address zero that runs every instruction once. The data it
  // works on sits at 0xC8..0xCD: two words, two pointers to them and two store targets.
  localparam word_t DEMO_PROG [42] = '{
    OP_LOAD_IMM, 8'h7F,  OP_ADD_IMM, 8'h01,   OP_SUB_IMM, 8'h01,   OP_NAND_IMM, 8'hFF,
    OP_ADD_DIR, 8'hC8,   OP_SUB_DIR, 8'hC9,   OP_NAND_DIR, 8'hC8,  OP_LOAD_DIR, 8'hC8,
    OP_LOAD_IND, 8'hCA,  OP_ADD_IND, 8'hCB,   OP_SUB_IND, 8'hCB,   OP_NAND_IND, 8'hCA,
    OP_STORE_DIR, 8'hCC, OP_STORE_IND, 8'hCB, OP_IN_DIR, 8'hCD,    OP_IN_IND, 8'hCA,
    OP_OUT_DIR, 8'hCD,   OP_OUT_IND, 8'hCB,   OP_BRN, 8'h00,       OP_BRZ, 8'h00,
    OP_JUMP, 8'hFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = '0;
  logic [7:0] address = '0;
  logic signed [7:0] data = '0;
  logic check_breaks = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic out_valid;
  logic signed [7:0] out_value;
  logic signed [7:0] read_data;
  logic [7:0] pc_now;
  logic signed [7:0] acc_now;
  logic [7:0] last_opcode;

  accumulator_cpu_step DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .address(address),
    .data(data),
    .check_breaks(check_breaks),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .out_valid(out_valid),
    .out_value(out_value),
    .read_data(read_data),
    .pc_now(pc_now),
    .acc_now(acc_now),
    .last_opcode(last_opcode)
  );

  // Commands waiting for their transfer, and results predicted for commands already
  // transferred, oldest first.
  cmd_t cmd_queue[$];
  step_result_t step_results[$];

  // Our own copy of the machine: memory, program counter, accumulator, halt flag and
  // the breakpoint registers as last written.
  word_t shadow_mem [MEM_DEPTH];
  addr_t shadow_pc = '0;
  word_t shadow_acc = '0;
  logic shadow_halt = 1'b0;
  logic [BREAK_SLOTS-1:0] brk_en = '0;
  word_t brk_op [BREAK_SLOTS] = '{default: '0};

  int idle_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  step_result_t got, want;

  initial begin
    forever #4 clk = ~clk;
  end

  // Applies one command to the copy of the machine and returns the result the block
  // must report for it.
  function automatic step_result_t cpu_step(input cmd_t c);
    step_result_t r;
    word_t op, arg, ptr, acc_next;
    addr_t pc_next;
    logic legal, hit;
    r = '0;
    r.status = ST_DONE;
    case (c.action)
      ACT_WRITE: shadow_mem[c.address] = c.data;
      ACT_READ:  r.read_data = shadow_mem[c.address];
      ACT_START: begin
        shadow_pc = c.address;
        shadow_acc = '0;
        shadow_halt = 1'b0;
      end
      default: begin
        if (shadow_halt) begin
          r.status = ST_REFUSED;
        end else begin
          op = shadow_mem[shadow_pc];
          r.opcode = op;
          hit = 1'b0;
          for (int i = 0; i < BREAK_SLOTS; i++)
            if (c.check_breaks && brk_en[i] && brk_op[i] == op) hit = 1'b1;
          if (hit) begin
            r.status = ST_BREAK;
          end else begin
            // Operand word follows the opcode; both reads wrap around the memory.
            arg = shadow_mem[addr_t'(shadow_pc + 1)];
            ptr = shadow_mem[arg];
            pc_next = addr_t'(shadow_pc + 2);
            acc_next = shadow_acc;
            legal = 1'b1;
            case (op)
              OP_LOAD_IMM:  acc_next = arg;
              OP_LOAD_DIR:  acc_next = shadow_mem[arg];
              OP_LOAD_IND:  acc_next = shadow_mem[ptr];
              OP_ADD_IMM:   acc_next = shadow_acc + arg;
              OP_ADD_DIR:   acc_next = shadow_acc + shadow_mem[arg];
              OP_ADD_IND:   acc_next = shadow_acc + shadow_mem[ptr];
              OP_SUB_IMM:   acc_next = shadow_acc - arg;
              OP_SUB_DIR:   acc_next = shadow_acc - shadow_mem[arg];
              OP_SUB_IND:   acc_next = shadow_acc - shadow_mem[ptr];
              OP_NAND_IMM:  acc_next = ~(shadow_acc & arg);
              OP_NAND_DIR:  acc_next = ~(shadow_acc & shadow_mem[arg]);
              OP_NAND_IND:  acc_next = ~(shadow_acc & shadow_mem[ptr]);
              OP_STORE_DIR: shadow_mem[arg] = shadow_acc;
              OP_STORE_IND: shadow_mem[ptr] = shadow_acc;
              OP_IN_DIR:    shadow_mem[arg] = c.data;
              OP_IN_IND:    shadow_mem[ptr] = c.data;
              OP_OUT_DIR: begin
                r.out_valid = 1'b1;
                r.out_value = shadow_mem[arg];
              end
              OP_OUT_IND: begin
                r.out_valid = 1'b1;
                r.out_value = shadow_mem[ptr];
              end
              OP_JUMP:      pc_next = arg;
              OP_BRN:       if (shadow_acc[WORD_BITS-1]) pc_next = arg;
              OP_BRZ:       if (shadow_acc == '0) pc_next = arg;
              default:      legal = 1'b0;
            endcase
            // An unknown opcode leaves everything in place and halts the machine.
            if (legal) begin
              shadow_acc = acc_next;
              shadow_pc = pc_next;
            end else begin
              shadow_halt = 1'b1;
              r.status = ST_INVALID;
            end
          end
        end
      end
    endcase
    r.pc = shadow_pc;
    r.acc = shadow_acc;
    return r;
  endfunction

  // Random word with the corner values of a signed byte drawn often.
  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Mostly a legal opcode, now and then any byte at all.
  function automatic word_t pick_opcode();
    if ($urandom_range(7) == 0) return word_t'($urandom);
    return LEGAL_OPS[$urandom_range(20)];
  endfunction

  function automatic void add_cmd(input action_t act, input addr_t where, input word_t value,
                                  input logic chk);
    cmd_t c;
    c.action = act;
    c.address = where;
    c.data = value;
    c.check_breaks = chk;
    cmd_queue.push_back(c);
  endfunction

  // A well-formed burst: write a few instructions at a random base, usually restart
  // there, then single-step through them. Jumps and branches aim back into the
  // program so that loops and taken branches come up often.
  function automatic void queue_program();
    addr_t base;
    word_t op, arg;
    int n, steps;
    base = addr_t'($urandom);
    n = $urandom_range(2, 8);
    for (int j = 0; j < n; j++) begin
      op = pick_opcode();
      if (op == OP_JUMP || op == OP_BRN || op == OP_BRZ)
        arg = word_t'(base + 2 * $urandom_range(n - 1));
      else
        arg = pick_word();
      add_cmd(ACT_WRITE, addr_t'(base + 2 * j), op, 1'($urandom_range(1)));
      add_cmd(ACT_WRITE, addr_t'(base + 2 * j + 1), arg, 1'($urandom_range(1)));
    end
    if ($urandom_range(7) != 0) add_cmd(ACT_START, base, pick_word(), 1'($urandom_range(1)));
    steps = n + $urandom_range(3);
    for (int j = 0; j < steps; j++) begin
      if ($urandom_range(9) == 0)
        add_cmd(ACT_READ, addr_t'($urandom), pick_word(), 1'($urandom_range(1)));
      add_cmd(ACT_EXEC, addr_t'($urandom), pick_word(), $urandom_range(3) == 0);
    end
  endfunction

  // Writes every breakpoint register; the copy follows at once since the block is idle.
  task automatic load_breaks(input logic [3:0] en, input word_t o0, input word_t o1,
                             input word_t o2, input word_t o3);
    word_t ops [4];
    ops = '{o0, o1, o2, o3};
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_BREAK_EN;
    cfg_data <= CFG_DATA_BITS'(en);
    brk_en = BREAK_SLOTS'(en);
    for (int i = 0; i < BREAK_SLOTS; i++) begin
      @(posedge clk);
      cfg_index <= CFG_INDEX_BITS'(REG_BREAK_OP0 + i);
      cfg_data <= ops[i];
      brk_op[i] = ops[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Returns once every command has had its transfer and every result has come back,
  // then waits out SETTLE_CYCLES so that the block is surely idle.
  task automatic wait_drained();
    do @(negedge clk); while (cmd_queue.size() != 0 || step_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver. A command transfers at an edge where start is high and busy is low; its
  // result is predicted right there. While start is high and busy, the command is
  // held. Otherwise the next command is offered, or the sender idles at the rate of
  // the current phase.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) step_results.push_back(cpu_step(cmd_queue.pop_front()));
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          action <= cmd_queue[0].action;
          address <= cmd_queue[0].address;
          data <= cmd_queue[0].data;
          check_breaks <= cmd_queue[0].check_breaks;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result is valid for the single cycle in which done is high and is
  // compared as a whole with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      got = {status, out_valid, out_value, read_data, pc_now, acc_now, last_opcode};
      if (step_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with no command outstanding: status=%0d pc=%h acc=%h",
                   $realtime, got.status, got.pc, got.acc);
      end else begin
        want = step_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected status=%0d out=%b/%h read=%h pc=%h acc=%h opcode=%h",
                     want.status, want.out_valid, want.out_value, want.read_data,
                     want.pc, want.acc, want.opcode);
            $display("  actual   status=%0d out=%b/%h read=%h pc=%h acc=%h opcode=%h",
                     got.status, got.out_valid, got.out_value, got.read_data,
                     got.pc, got.acc, got.opcode);
          end
        end
      end
    end
  end

  // Watchdog: a run that stops making transfers is hung.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    word_t image [MEM_DEPTH];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Memory comes out of reset undefined, so every word is written before anything
    // reads it. The image carries the demo program and its data; the rest is random.
    foreach (image[a]) image[a] = ($urandom_range(2) == 0) ? pick_opcode() : pick_word();
    foreach (DEMO_PROG[i]) image[i] = DEMO_PROG[i];
    image[8'hC8] = 8'h7F;
    image[8'hC9] = 8'h80;
    image[8'hCA] = 8'hC9;
    image[8'hCB] = 8'hC8;
    // The jump lands on the last word, so the operand fetch wraps to address zero and
    // the next instruction is taken from address one, which holds an unknown opcode.
    image[8'hFF] = OP_ADD_IMM;
    idle_pct = 0;
    foreach (image[a]) add_cmd(ACT_WRITE, addr_t'(a), image[a], 1'($urandom_range(1)));
    wait_drained();

    // Directed part. Only slot zero is enabled, on the opcode at address zero; slot
    // one holds ADD_IMM but is disabled, so that instruction runs with the check on.
    load_breaks(4'b0001, OP_LOAD_IMM, OP_ADD_IMM, 8'hFF, OP_JUMP);
    idle_pct = 35;
    // Walk the demo program, the wrapped instruction and the halt; the two IN
    // instructions take the extreme data values.
    for (int i = 0; i < 23; i++)
      add_cmd(ACT_EXEC, addr_t'($urandom),
              (i == 14) ? 8'h80 : (i == 15) ? 8'h7F : pick_word(), i != 0);
    // Halted: an execute is refused, a read still works, and a start lifts the halt.
    add_cmd(ACT_EXEC, addr_t'($urandom), pick_word(), 1'b1);
    add_cmd(ACT_READ, 8'hFF, pick_word(), 1'b0);
    add_cmd(ACT_START, 8'h00, pick_word(), 1'b1);
    // Opcode at address zero matches the enabled slot: breakpoint stop, then run it.
    add_cmd(ACT_EXEC, addr_t'($urandom), pick_word(), 1'b1);
    add_cmd(ACT_EXEC, addr_t'($urandom), pick_word(), 1'b0);
    wait_drained();

    // Random phases, each with its own breakpoint setting and idle rate. The first two
    // take the extremes: all slots off on opcode zero, then all slots on, one of them
    // on an opcode that is not legal.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_breaks(4'h0, 8'h00, 8'h00, 8'h00, 8'h00);
        1: load_breaks(4'hF, OP_JUMP, OP_ADD_IMM, OP_STORE_DIR, 8'hFF);
        default: load_breaks(4'($urandom), pick_opcode(), pick_opcode(), pick_opcode(),
                             pick_opcode());
      endcase
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 88;
        default: idle_pct = 35;
      endcase
      while (cmd_queue.size() < PHASE_CMDS) begin
        if ($urandom_range(4) == 0)
          add_cmd(action_t'($urandom_range(3)), addr_t'($urandom), word_t'($urandom),
                  1'($urandom_range(1)));
        else
          queue_program();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
